>>> sv/dpr_pkg.sv
// Shared constants for the disparity-to-point reprojection unit.
// No dependencies; imported by dpr_div, the top level and the testbench.
`timescale 1ns / 1ps

package dpr_pkg;

    localparam int DISP_W   = 16;
    localparam int COORD_W  = 32;
    localparam int BASE_W   = 24;
    localparam int FOCAL_W  = 20;
    localparam int CENTER_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int Z_Q_W    = 31;
    localparam int FOCAL_FRAC = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE = 3'd0,
        CFG_FOCAL_X  = 3'd1,
        CFG_FOCAL_Y  = 3'd2,
        CFG_CENTER_X = 3'd3,
        CFG_CENTER_Y = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic point_valid;
        logic saturated;
    } t_flags;

endpackage

>>> sv/disparity_to_point_reprojection_unit.sv
// Top level: stereo disparity to 3D point reprojection, streaming in and out.
// Depends on dpr_pkg and dpr_div.
`timescale 1ns / 1ps

// Takes one item per clock while o_s_axis_tready is high and returns one point
// per item, in order. An accepted item passes an input register, a multiply
// stage, the 32-stage depth divider, a multiply stage, the 33-stage x/y dividers
// and the output register. Throughput is one item per cycle while the skid is
// empty; an output skid register holds one extra item while the sink stalls.
// Config writes take effect at once and must be issued with no item in flight.
module disparity_to_point_reprojection_unit
    import dpr_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int DISP_FRAC_BITS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // disparity, pixel_row, pixel_col, zero fill
    input  logic [((DISP_W+2*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // point_x, point_y, point_z
    output logic [3*COORD_W-1:0] o_m_axis_tdata,
    // point_valid, saturated
    output logic [1:0] o_m_axis_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int MAG_W   = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
    localparam int BF_W    = BASE_W + FOCAL_W;
    localparam int SHIFT_Z = FOCAL_FRAC - DISP_FRAC_BITS;
    localparam int SIDE_Z  = 2 * MAG_W + 3;
    localparam int PROD_W  = MAG_W + Z_Q_W;
    localparam int NUM_XY  = PROD_W + 4;
    localparam int SIDE_X  = Z_Q_W + 3;

    logic [BASE_W-1:0]   r_baseline;
    logic [FOCAL_W-1:0]  r_focal_x;
    logic [FOCAL_W-1:0]  r_focal_y;
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= '0;
            r_focal_x  <= FOCAL_W'(256);
            r_focal_y  <= FOCAL_W'(256);
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASELINE: r_baseline <= i_cfg_data[BASE_W-1:0];
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data[FOCAL_W-1:0];
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data[FOCAL_W-1:0];
                CFG_CENTER_X: r_center_x <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_skid_v;
    assign en = !r_skid_v;
    assign o_s_axis_tready = en;

    // input stage
    logic                  r_s0_v;
    logic [DISP_W-1:0]     r_s0_disp;
    logic [COORD_BITS-1:0] r_s0_row;
    logic [COORD_BITS-1:0] r_s0_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_disp <= i_s_axis_tdata[DISP_W-1:0];
            r_s0_row  <= i_s_axis_tdata[DISP_W +: COORD_BITS];
            r_s0_col  <= i_s_axis_tdata[DISP_W+COORD_BITS +: COORD_BITS];
        end
    end

    // multiply stage: baseline * focal_x, pixel offsets
    logic             pos;
    logic [BF_W-1:0]  bf;
    logic [MAG_W:0]   px, py, cx, cy;
    logic             neg_x, neg_y;
    logic [MAG_W-1:0] mag_x, mag_y;

    always_comb begin
        pos   = !r_s0_disp[DISP_W-1] && (r_s0_disp != '0);
        bf    = BF_W'(r_baseline) * BF_W'(r_focal_x);
        px    = (MAG_W+1)'({r_s0_col, 4'b0});
        py    = (MAG_W+1)'({r_s0_row, 4'b0});
        cx    = (MAG_W+1)'(r_center_x);
        cy    = (MAG_W+1)'(r_center_y);
        neg_x = px < cx;
        neg_y = py < cy;
        mag_x = neg_x ? MAG_W'(cx - px) : MAG_W'(px - cx);
        mag_y = neg_y ? MAG_W'(cy - py) : MAG_W'(py - cy);
    end

    logic                r_s1_v;
    logic [BF_W-1:0]     r_s1_num;
    logic [DISP_W-2:0]   r_s1_den;
    logic [SIDE_Z-1:0]   r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_num  <= bf >> SHIFT_Z;
            r_s1_den  <= pos ? r_s0_disp[DISP_W-2:0] : '0;
            r_s1_side <= {pos, neg_y, mag_y, neg_x, mag_x};
        end
    end

    logic              zd_v, zd_ovf;
    logic [Z_Q_W-1:0]  zd_q;
    logic [SIDE_Z-1:0] zd_side;

    dpr_div #(
        .NUM_W (BF_W),
        .DEN_W (DISP_W - 1),
        .Q_W   (Z_Q_W),
        .SIDE_W(SIDE_Z)
    ) u_div_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_s1_v),
        .i_num  (r_s1_num),
        .i_den  (r_s1_den),
        .i_side (r_s1_side),
        .o_valid(zd_v),
        .o_quo  (zd_q),
        .o_ovf  (zd_ovf),
        .o_side (zd_side)
    );

    // depth clamp and offset * depth
    logic [Z_Q_W-1:0] z;
    assign z = zd_ovf ? '1 : zd_q;

    logic                r_s2_v;
    logic [PROD_W-1:0]   r_s2_px;
    logic [PROD_W-1:0]   r_s2_py;
    logic [SIDE_X-1:0]   r_s2_side;
    logic                r_s2_neg_y;
    logic [FOCAL_W-1:0]  den_x, den_y;

    assign den_x = (r_focal_x == '0) ? FOCAL_W'(1) : r_focal_x;
    assign den_y = (r_focal_y == '0) ? FOCAL_W'(1) : r_focal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= zd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_px    <= PROD_W'(zd_side[MAG_W-1:0]) * PROD_W'(z);
            r_s2_py    <= PROD_W'(zd_side[2*MAG_W:MAG_W+1]) * PROD_W'(z);
            r_s2_side  <= {z, zd_ovf, zd_side[MAG_W], zd_side[SIDE_Z-1]};
            r_s2_neg_y <= zd_side[2*MAG_W+1];
        end
    end

    logic              xd_v, xd_ovf, yd_v, yd_ovf, yd_neg;
    logic [COORD_W-1:0] xd_q, yd_q;
    logic [SIDE_X-1:0]  xd_side;

    dpr_div #(
        .NUM_W (NUM_XY),
        .DEN_W (FOCAL_W),
        .Q_W   (COORD_W),
        .SIDE_W(SIDE_X)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_s2_v),
        .i_num  ({r_s2_px, 4'b0}),
        .i_den  (den_x),
        .i_side (r_s2_side),
        .o_valid(xd_v),
        .o_quo  (xd_q),
        .o_ovf  (xd_ovf),
        .o_side (xd_side)
    );

    dpr_div #(
        .NUM_W (NUM_XY),
        .DEN_W (FOCAL_W),
        .Q_W   (COORD_W),
        .SIDE_W(1)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_s2_v),
        .i_num  ({r_s2_py, 4'b0}),
        .i_den  (den_y),
        .i_side (r_s2_neg_y),
        .o_valid(yd_v),
        .o_quo  (yd_q),
        .o_ovf  (yd_ovf),
        .o_side (yd_neg)
    );

    // clamp, apply sign; returns {sat, value}
    function automatic logic [COORD_W:0] clamp_coord(
        input logic               ovf,
        input logic [COORD_W-1:0] q,
        input logic               neg
    );
        logic [COORD_W-1:0] lim;
        logic               sat;
        lim = neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        sat = ovf || (q > lim);
        return {sat, sat ? (neg ? lim : lim) : (neg ? COORD_W'(-q) : q)};
    endfunction

    logic [COORD_W:0]   cx_res, cy_res;
    logic [COORD_W-1:0] fz;
    logic               f_pos, f_sat, new_v;
    logic [3*COORD_W-1:0] new_data;
    t_flags             new_flags;

    always_comb begin
        cx_res = clamp_coord(xd_ovf, xd_q, xd_side[1]);
        cy_res = clamp_coord(yd_ovf, yd_q, yd_neg);
        fz     = COORD_W'(xd_side[SIDE_X-1:3]);
        f_pos  = xd_side[0];
        f_sat  = xd_side[2] || cx_res[COORD_W] || cy_res[COORD_W];
        new_v  = xd_v && yd_v && en;
        if (f_pos) begin
            new_data  = {fz, cy_res[COORD_W-1:0], cx_res[COORD_W-1:0]};
            new_flags = '{point_valid: 1'b1, saturated: f_sat};
        end else begin
            new_data  = '0;
            new_flags = '{point_valid: 1'b0, saturated: 1'b0};
        end
    end

    // output register and skid
    logic                 r_out_v;
    logic [3*COORD_W-1:0] r_out_data, r_skid_data;
    t_flags               r_out_flags, r_skid_flags;
    logic                 out_free;

    assign out_free = !r_out_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= new_v;
            end
        end else if (new_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out_data  <= r_skid_data;
                r_out_flags <= r_skid_flags;
            end else begin
                r_out_data  <= new_data;
                r_out_flags <= new_flags;
            end
        end else if (new_v) begin
            r_skid_data  <= new_data;
            r_skid_flags <= new_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_flags.saturated, r_out_flags.point_valid};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_axis_tready))
        else $error("skid filled without an output stall");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_flags.point_valid) |-> (r_out_data == '0 && !r_out_flags.saturated))
        else $error("unmatched pixel produced nonzero point");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xd_v == yd_v)
        else $error("x and y dividers out of step");

endmodule

>>> sv/dpr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on dpr_pkg.
`timescale 1ns / 1ps

module dpr_div
    import dpr_pkg::*;
#(
    parameter int NUM_W  = 51,
    parameter int DEN_W  = 20,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic              r_vld  [Q_W+1];
    logic              r_ovf  [Q_W+1];
    logic [DEN_W-1:0]  r_rem  [Q_W+1];
    logic [Q_W-1:0]    r_low  [Q_W+1];
    logic [Q_W-1:0]    r_quo  [Q_W+1];
    logic [DEN_W-1:0]  r_den  [Q_W+1];
    logic [SIDE_W-1:0] r_side [Q_W+1];

    logic [DEN_W:0]   n_t   [Q_W+1];
    logic             n_ge  [Q_W+1];
    logic [DEN_W-1:0] n_rem [Q_W+1];
    logic             n_ovf0;

    always_comb begin
        n_ovf0 = CW'(i_num >> Q_W) >= CW'(i_den);
        n_t[0]   = '0;
        n_ge[0]  = 1'b0;
        n_rem[0] = '0;
        for (int k = 1; k <= Q_W; k++) begin
            n_t[k]   = {r_rem[k-1], r_low[k-1][Q_W-1]};
            n_ge[k]  = n_t[k] >= {1'b0, r_den[k-1]};
            n_rem[k] = n_ge[k] ? DEN_W'(n_t[k] - {1'b0, r_den[k-1]}) : DEN_W'(n_t[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= Q_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= n_ovf0;
            r_rem[0]  <= n_ovf0 ? '0 : DEN_W'(i_num >> Q_W);
            r_low[0]  <= i_num[Q_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k <= Q_W; k++) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= {r_low[k-1][Q_W-2:0], 1'b0};
                r_quo[k]  <= {r_quo[k-1][Q_W-2:0], n_ge[k]};
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

>>> tb/sv/tb_disparity_to_point_reprojection_unit.sv
// Testbench for disparity_to_point_reprojection_unit: streams disparity pixels
// under random idling and back-pressure and checks each 3D point and its flags.
// Depends on dpr_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_disparity_to_point_reprojection_unit;
    import dpr_pkg::*;

    localparam int IN_W  = ((DISP_W + 24 + 7) / 8) * 8;
    localparam int LATENCY = 69;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        pvalid;
        logic        sat;
    } t_point;

    typedef struct {
        logic [15:0] disp;
        logic [11:0] row;
        logic [11:0] col;
        bit          known;
        t_point      want;
    } t_pixel_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_axis_tvalid = 0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 0;
    logic [3*COORD_W-1:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    disparity_to_point_reprojection_unit uut (.*);

    logic [63:0] cam_base, cam_fx, cam_fy, cam_cx, cam_cy;
    t_point expected_points[$];
    int mismatches = 0;
    int points_seen = 0;
    int idle_cycles = 0;
    int sink_hold = 0;
    int sink_gap = 0;
    bit sink_burst = 0;
    bit timed_out = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic logic [31:0] scale_offset(logic [63:0] pix, logic [63:0] ctr,
            logic [63:0] z, logic [63:0] f, ref bit sat);
        logic [63:0] mag, d, q;
        bit neg;
        neg = (pix << 4) < ctr;
        mag = neg ? ctr - (pix << 4) : (pix << 4) - ctr;
        d = (f == 0) ? 64'd1 : f;
        q = (mag * z * 16) / d;
        if (neg) begin
            if (q > 64'd2147483648) begin
                q = 64'd2147483648;
                sat = 1;
            end
            return 32'(64'd0 - q);
        end
        if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            sat = 1;
        end
        return q[31:0];
    endfunction

    function automatic t_point reproject(logic [15:0] disp, logic [11:0] row,
            logic [11:0] col);
        t_point p;
        logic [63:0] z;
        bit sat;
        p = '0;
        sat = 0;
        if (disp == 0 || disp[15]) return p;
        z = ((cam_base * cam_fx) << 4) / ({48'd0, disp} << 8);
        if (z > 64'd2147483647) begin
            z = 64'd2147483647;
            sat = 1;
        end
        p.px = scale_offset(64'(col), cam_cx, z, cam_fx, sat);
        p.py = scale_offset(64'(row), cam_cy, z, cam_fy, sat);
        p.pz = z[31:0];
        p.pvalid = 1;
        p.sat = sat;
        return p;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_BASELINE: cam_base = 64'(val);
            CFG_FOCAL_X:  cam_fx = 64'(val[19:0]);
            CFG_FOCAL_Y:  cam_fy = 64'(val[19:0]);
            CFG_CENTER_X: cam_cx = 64'(val[15:0]);
            CFG_CENTER_Y: cam_cy = 64'(val[15:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_points();
        i_s_axis_tvalid <= 0;
        while (expected_points.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] disp, logic [11:0] row, logic [11:0] col,
            bit known, t_point want, bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                    : $urandom_range(10, 40)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= IN_W'({col, row, disp});
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_points.push_back(known ? want : reproject(disp, row, col));
    endtask

    task automatic random_frame(int count, int mode);
        logic [15:0] d;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: d = 16'($urandom_range(0, 65535));
                1: d = 16'h8000 | 16'($urandom_range(0, 32767));
                2: d = 16'($urandom_range(1, 15));
                default: d = 16'($urandom_range(16, 4095));
            endcase
            send_pixel(d, 12'($urandom), 12'($urandom), 0, '0, mode != 1);
        end
    endtask

    // sink: random stalls, a few longer gaps, plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
        end else if (sink_burst) begin
            i_m_axis_tready <= 0;
            sink_hold <= sink_hold + 1;
            if (sink_hold >= 300) begin
                sink_burst <= 0;
                sink_hold <= 0;
            end
        end else if (sink_gap != 0) begin
            i_m_axis_tready <= 0;
            sink_gap <= sink_gap - 1;
        end else begin
            if ($urandom_range(0, 199) == 0)
                sink_gap <= int'($urandom_range(10, 40));
            i_m_axis_tready <= ($urandom_range(0, 3) != 0)
                || ($urandom_range(0, 1) == 0 && points_seen % 100 > 70);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_point got, want;
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tdata[95:64],
                   o_m_axis_tuser[0], o_m_axis_tuser[1]};
            points_seen <= points_seen + 1;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point %h", got);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point %0d: want x=%h y=%h z=%h v=%b s=%b,",
                                  " got x=%h y=%h z=%h v=%b s=%b"},
                                 points_seen, want.px, want.py, want.pz, want.pvalid,
                                 want.sat, got.px, got.py, got.pz, got.pvalid, got.sat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_pixel_row directed[$];

    initial begin
        cam_base = 0; cam_fx = 256; cam_fy = 256; cam_cx = 0; cam_cy = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults after reset: zero baseline gives a valid zero point; zero and negative disparities give no point
        directed.push_back('{16'h0010, 12'd5, 12'd7, 1, '{0, 0, 0, 1, 0}});
        directed.push_back('{16'h7FFF, 12'hFFF, 12'hFFF, 1, '{0, 0, 0, 1, 0}});
        directed.push_back('{16'h0000, 12'd1, 12'd1, 1, '0});
        directed.push_back('{16'h8000, 12'hFFF, 12'd0, 1, '0});
        directed.push_back('{16'hFFFF, 12'd0, 12'hFFF, 1, '0});
        foreach (directed[k])
            send_pixel(directed[k].disp, directed[k].row, directed[k].col,
                       directed[k].known, directed[k].want, 0);
        drain_points();

        // extremes: max baseline and focal, center x mid-image, center y at its maximum, tiny disparity
        write_reg(CFG_BASELINE, 24'hFFFFFF);
        write_reg(CFG_FOCAL_X, 24'h0FFFFF);
        write_reg(CFG_FOCAL_Y, 24'h0FFFFF);
        write_reg(CFG_CENTER_X, 24'h008000);
        write_reg(CFG_CENTER_Y, 24'h00FFFF);
        write_reg(t_cfg_idx'(3'd6), 24'h123456);
        directed.delete();
        directed.push_back('{16'h0001, 12'd0, 12'd0, 0, '0});
        directed.push_back('{16'h7FFF, 12'hFFF, 12'hFFF, 0, '0});
        directed.push_back('{16'h0001, 12'hFFF, 12'hFFF, 0, '0});
        directed.push_back('{16'h0100, 12'd2048, 12'd1000, 0, '0});
        directed.push_back('{16'hFFF0, 12'd3, 12'd3, 1, '0});
        foreach (directed[k])
            send_pixel(directed[k].disp, directed[k].row, directed[k].col,
                       directed[k].known, directed[k].want, 0);
        drain_points();

        // zero focal length is used as one
        write_reg(CFG_FOCAL_X, 24'd0);
        write_reg(CFG_FOCAL_Y, 24'd0);
        write_reg(CFG_BASELINE, 24'd1000);
        send_pixel(16'h0010, 12'd100, 12'd200, 0, '0, 0);
        send_pixel(16'h7FFF, 12'd0, 12'hFFF, 0, '0, 0);
        drain_points();

        for (int ph = 0; ph < 5 && !timed_out; ph++) begin
            write_reg(CFG_BASELINE, 24'($urandom_range(0, ph == 4 ? 24'hFFFFFF : 24'h1FFFF)));
            write_reg(CFG_FOCAL_X, 24'($urandom_range(1, ph == 3 ? 20'hFFFFF : 20'h3FFFF)));
            write_reg(CFG_FOCAL_Y, 24'($urandom_range(1, ph == 3 ? 20'hFFFFF : 20'h3FFFF)));
            write_reg(CFG_CENTER_X, 24'($urandom_range(0, 65535)));
            write_reg(CFG_CENTER_Y, 24'($urandom_range(0, 65535)));
            if (ph == 2) sink_burst <= 1;
            random_frame(100, ph == 2 ? 1 : 0);
            drain_points();
        end

        drain_points();
        $display("covered %0d points over reset, extreme, zero-focal and five random camera setups",
                 points_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
